@@ src/svpwm_pkg.sv @@
// Shared types and constants of the servo pulse frame generator.
`default_nettype none

package svpwm_pkg;

    localparam int WIDTH_W    = 12;
    localparam int INTERVAL_W = 15;
    localparam int COUNT_W    = 32;

    localparam logic [WIDTH_W-1:0]    PULSE_MIN   = 12'd500;
    localparam logic [WIDTH_W-1:0]    PULSE_MAX   = 12'd2500;
    localparam logic [WIDTH_W-1:0]    PULSE_RESET = 12'd1500;
    localparam logic [WIDTH_W-1:0]    ELAPSED_MAX = 12'hFFF;
    localparam logic [INTERVAL_W-1:0] FRAME_US    = 15'd20000;
    localparam logic [INTERVAL_W-1:0] MIN_RELOAD  = 15'd1;

    typedef enum logic [1:0] {
        OP_TIMER = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_BUSY    = 2'd2
    } status_t;

    // What one channel lane reports for the current word.
    typedef struct packed {
        logic               width_ok;
        logic               due;
        logic               cand_valid;
        logic [WIDTH_W-1:0] width;
    } lane_res_t;

    // What the merging stage finds across all lanes.
    typedef struct packed {
        logic               all_ok;
        logic               found;
        logic [WIDTH_W-1:0] edge_width;
        logic [WIDTH_W-1:0] first_width;
    } merge_res_t;

    // One result word as it waits in the output buffer.
    typedef struct packed {
        status_t               status;
        logic [3:0]            pins_high_mask;
        logic [3:0]            pins_low_mask;
        logic                  reload_timer;
        logic [INTERVAL_W-1:0] next_interval;
        logic [COUNT_W-1:0]    frame_count;
        logic                  is_running;
    } result_t;

endpackage

`default_nettype wire

@@ src/svpwm_lane.sv @@
// One channel lane: range check of a new width and edge compare against elapsed time.
`default_nettype none

module svpwm_lane (
    input  wire logic [svpwm_pkg::WIDTH_W-1:0] wr_width,
    input  wire logic [svpwm_pkg::WIDTH_W-1:0] active_width,
    input  wire logic [svpwm_pkg::WIDTH_W-1:0] elapsed,
    input  wire logic                          pending,
    output svpwm_pkg::lane_res_t               res
);

    logic due;

    // The channel falls once the elapsed time has reached its width.
    assign due = pending && (active_width <= elapsed);

    assign res.width_ok   = (wr_width >= svpwm_pkg::PULSE_MIN) &&
                            (wr_width <= svpwm_pkg::PULSE_MAX);
    assign res.due        = due;
    assign res.cand_valid = pending && !due;
    assign res.width      = active_width;

endmodule

`default_nettype wire

@@ src/svpwm_merge.sv @@
// Merging stage: combines the lane reports into masks and earliest edges.
`default_nettype none

module svpwm_merge #(
    parameter int CHANNELS = 4
) (
    input  wire svpwm_pkg::lane_res_t          lanes [CHANNELS],
    input  wire logic [svpwm_pkg::WIDTH_W-1:0] shadow [CHANNELS],
    output logic [CHANNELS-1:0]                due_mask,
    output svpwm_pkg::merge_res_t              res
);

    always_comb begin
        res.all_ok      = 1'b1;
        res.found       = 1'b0;
        res.edge_width  = svpwm_pkg::PULSE_MAX;
        res.first_width = svpwm_pkg::PULSE_MAX;
        due_mask        = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            res.all_ok  = res.all_ok & lanes[i].width_ok;
            due_mask[i] = lanes[i].due;
            // The first waiting channel sets the edge, later ones only lower it.
            if (lanes[i].cand_valid && (!res.found || lanes[i].width < res.edge_width)) begin
                res.edge_width = lanes[i].width;
                res.found      = 1'b1;
            end
            if (shadow[i] < res.first_width) begin
                res.first_width = shadow[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/servo_pwm_frame_generator_core.sv @@
// Top level of the event-driven multichannel servo pulse frame generator.
`default_nettype none

// Each input word is one event: a timer expiry, start, stop or a write of new
// shadow pulse widths. The block answers every word with exactly one result
// word that says which pins to drive high or low, whether the timer is to be
// reloaded and with how many microseconds, the frame count and the running
// flag. A frame lasts 20000 us; at its start the shadow widths are latched,
// all pins rise, and each pin falls once the elapsed frame time reaches its
// width. Widths outside 500 to 2500 us are refused with an invalid status.
// The block takes one word per clock cycle while s_axis_tready is high and
// registers its result: all channels are compared in parallel lanes and the state of the scheduler is
// updated in the cycle in which a word is accepted. Results pass through a
// two-entry output buffer, so a new word is still accepted while one result
// waits; s_axis_tready falls only when both entries are occupied.
module servo_pwm_frame_generator_core #(
    parameter int CHANNELS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // width_ch0 [11:0], width_ch1 [23:12], width_ch2 [35:24], width_ch3 [47:36]
    input  wire logic [47:0] s_axis_tdata,
    // operation [1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pins_high_mask [3:0], pins_low_mask [7:4], reload_timer [8],
    // next_interval [23:9], frame_count [55:24], is_running [56], zero [63:57]
    output logic [63:0]      m_axis_tdata,
    // status [1:0]
    output logic [1:0]       m_axis_tuser
);

    localparam int WW     = svpwm_pkg::WIDTH_W;
    localparam int IW     = svpwm_pkg::INTERVAL_W;
    localparam int MASK_W = (CHANNELS > 4) ? CHANNELS : 4;

    // Scheduler state.
    logic [WW-1:0]                   shadow_reg  [CHANNELS];
    logic [WW-1:0]                   shadow_next [CHANNELS];
    logic [WW-1:0]                   active_reg  [CHANNELS];
    logic [WW-1:0]                   active_next [CHANNELS];
    logic [WW-1:0]                   elapsed_reg,  elapsed_next;
    logic [IW-1:0]                   interval_reg, interval_next;
    logic [CHANNELS-1:0]             pending_reg,  pending_next;
    logic                            running_reg,  running_next;
    logic                            gap_reg,      gap_next;
    logic [svpwm_pkg::COUNT_W-1:0]   frame_reg,    frame_next;

    // Output buffer: a main entry that drives the port and a skid entry.
    svpwm_pkg::result_t main_reg, main_next;
    svpwm_pkg::result_t skid_reg, skid_next;
    logic               main_valid_reg, main_valid_next;
    logic               skid_valid_reg, skid_valid_next;

    logic               s_accept;
    logic               m_take;
    svpwm_pkg::op_t     op;
    svpwm_pkg::result_t res;

    logic [WW-1:0]          wr_width [CHANNELS];
    logic [WW-1:0]          elapsed_sum;
    logic [IW:0]            elapsed_wide;
    logic [WW-1:0]          elapsed_e;
    svpwm_pkg::lane_res_t   lane_res [CHANNELS];
    svpwm_pkg::merge_res_t  merge_res;
    logic [CHANNELS-1:0]    due_mask;
    logic [CHANNELS-1:0]    hi_mask, lo_mask;
    logic [MASK_W-1:0]      hi_wide, lo_wide;
    logic [IW-1:0]          e_ext;
    logic [IW-1:0]          edge_ext;
    logic [IW-1:0]          first_ext;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_take        = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign op            = svpwm_pkg::op_t'(s_axis_tuser);

    // Elapsed frame time after this expiry, held at the top of its range.
    assign elapsed_wide = {4'b0, elapsed_reg} + {1'b0, interval_reg};
    assign elapsed_sum  = elapsed_wide[WW-1:0];
    assign elapsed_e    = (elapsed_wide > {4'b0, svpwm_pkg::ELAPSED_MAX})
                          ? svpwm_pkg::ELAPSED_MAX : elapsed_sum;
    assign e_ext        = {3'b0, elapsed_e};
    assign edge_ext     = {3'b0, merge_res.edge_width};
    assign first_ext    = {3'b0, merge_res.first_width};

    // One lane per channel; channels beyond the fourth read the last width field.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        localparam int F = (i < 4) ? i : 3;
        assign wr_width[i] = s_axis_tdata[F*WW +: WW];

        svpwm_lane u_lane (
            .wr_width     (wr_width[i]),
            .active_width (active_reg[i]),
            .elapsed      (elapsed_e),
            .pending      (pending_reg[i]),
            .res          (lane_res[i])
        );
    end

    svpwm_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .lanes    (lane_res),
        .shadow   (shadow_reg),
        .due_mask (due_mask),
        .res      (merge_res)
    );

    // Next state and the result word for the event on the input.
    always_comb begin
        shadow_next   = shadow_reg;
        active_next   = active_reg;
        elapsed_next  = elapsed_reg;
        interval_next = interval_reg;
        pending_next  = pending_reg;
        running_next  = running_reg;
        gap_next      = gap_reg;
        frame_next    = frame_reg;
        hi_mask       = '0;
        lo_mask       = '0;
        res           = '0;
        res.status    = svpwm_pkg::ST_OK;

        case (op)
            svpwm_pkg::OP_WRITE: begin
                if (merge_res.all_ok) begin
                    shadow_next = wr_width;
                end else begin
                    res.status = svpwm_pkg::ST_INVALID;
                end
            end
            svpwm_pkg::OP_START: begin
                if (running_reg) begin
                    res.status = svpwm_pkg::ST_BUSY;
                end else begin
                    lo_mask           = '1;
                    running_next      = 1'b1;
                    gap_next          = 1'b1;
                    res.reload_timer  = 1'b1;
                    res.next_interval = svpwm_pkg::MIN_RELOAD;
                    interval_next     = svpwm_pkg::MIN_RELOAD;
                end
            end
            svpwm_pkg::OP_STOP: begin
                running_next = 1'b0;
                pending_next = '0;
                lo_mask      = '1;
            end
            svpwm_pkg::OP_TIMER: begin
                if (!running_reg) begin
                    lo_mask = '1;
                end else if (gap_reg) begin
                    // New frame: latch the shadow widths and raise every pin.
                    active_next       = shadow_reg;
                    elapsed_next      = '0;
                    pending_next      = '1;
                    gap_next          = 1'b0;
                    frame_next        = frame_reg + 32'd1;
                    hi_mask           = '1;
                    res.reload_timer  = 1'b1;
                    res.next_interval = (first_ext == '0) ? svpwm_pkg::MIN_RELOAD : first_ext;
                    interval_next     = res.next_interval;
                end else begin
                    elapsed_next     = elapsed_e;
                    lo_mask          = due_mask;
                    pending_next     = pending_reg & ~due_mask;
                    res.reload_timer = 1'b1;
                    if (pending_next == '0) begin
                        // Last edge passed: wait out the rest of the frame.
                        gap_next          = 1'b1;
                        res.next_interval = (e_ext < svpwm_pkg::FRAME_US)
                                            ? svpwm_pkg::FRAME_US - e_ext
                                            : svpwm_pkg::MIN_RELOAD;
                    end else begin
                        res.next_interval = (edge_ext > e_ext) ? edge_ext - e_ext
                                                               : svpwm_pkg::MIN_RELOAD;
                    end
                    interval_next = res.next_interval;
                end
            end
            default: begin
                res.status = svpwm_pkg::ST_OK;
            end
        endcase

        hi_wide            = MASK_W'(hi_mask);
        lo_wide            = MASK_W'(lo_mask);
        res.pins_high_mask = hi_wide[3:0];
        res.pins_low_mask  = lo_wide[3:0];
        res.frame_count    = frame_next;
        res.is_running     = running_next;
    end

    // Output buffer control. The skid entry fills only when the main entry is
    // held by the sink, and it drains into the main entry first.
    always_comb begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (m_take) begin
            if (skid_valid_reg) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else if (s_accept) begin
                main_next = res;
            end else begin
                main_valid_next = 1'b0;
            end
        end else if (s_accept) begin
            if (!main_valid_reg) begin
                main_next       = res;
                main_valid_next = 1'b1;
            end else begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                shadow_reg[i] <= svpwm_pkg::PULSE_RESET;
                active_reg[i] <= svpwm_pkg::PULSE_RESET;
            end
            elapsed_reg    <= '0;
            interval_reg   <= svpwm_pkg::MIN_RELOAD;
            pending_reg    <= '0;
            running_reg    <= 1'b0;
            gap_reg        <= 1'b1;
            frame_reg      <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                shadow_reg   <= shadow_next;
                active_reg   <= active_next;
                elapsed_reg  <= elapsed_next;
                interval_reg <= interval_next;
                pending_reg  <= pending_next;
                running_reg  <= running_next;
                gap_reg      <= gap_next;
                frame_reg    <= frame_next;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign m_axis_tvalid = main_valid_reg;
    assign m_axis_tuser  = main_reg.status;
    assign m_axis_tdata  = {7'b0, main_reg.is_running, main_reg.frame_count,
                            main_reg.next_interval, main_reg.reload_timer,
                            main_reg.pins_low_mask, main_reg.pins_high_mask};

`ifndef SYNTHESIS
    // The timer is never asked to run for zero microseconds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        interval_reg != '0)
        else $error("timer interval register holds zero");

    // Outside the gap a running generator always has a pin still to fall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg && !gap_reg) |-> (pending_reg != '0))
        else $error("running outside the gap with no pending channel");

    // The skid entry is used only behind a full main entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry valid while main entry empty");

    // A start while stopped leaves the generator running in the gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (op == svpwm_pkg::OP_START) && !running_reg)
        |=> (running_reg && gap_reg))
        else $error("start did not enter the running gap");

    // A reload offered on the output is never of zero length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && main_reg.reload_timer) |-> (main_reg.next_interval != '0))
        else $error("reload of zero microseconds offered");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the servo pulse frame generator core.

module testbench;

    localparam logic [3:0] ALL_CHANNELS = 4'hF;

    // Clock and the block's inputs, all known from time zero.
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [47:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = svpwm_pkg::OP_TIMER;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Our own copy of the scheduler state, kept in step with every accepted word.
    logic [11:0] shadow_w [4];
    logic [11:0] active_w [4];
    logic [11:0] elapsed_us;
    logic [14:0] reload_us;
    logic [3:0]  falling_due;
    bit          running;
    bit          in_gap;
    logic [31:0] frames_begun;

    // Result words that the block still owes us, oldest first.
    svpwm_pkg::result_t scheduler_replies [$];

    bit          idling_on = 1'b1;
    int unsigned error_count = 0;
    int unsigned words_checked = 0;
    int unsigned refused_writes = 0;
    int unsigned busy_replies = 0;
    int unsigned events_by_op [4] = '{0, 0, 0, 0};

    servo_pwm_frame_generator_core #(
        .CHANNELS(4)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [47:0] pack_widths(logic [11:0] w0, logic [11:0] w1,
                                                logic [11:0] w2, logic [11:0] w3);
        return {w3, w2, w1, w0};
    endfunction

    // Advances the scheduler copy by one event and returns the word it should answer with.
    function automatic svpwm_pkg::result_t step_frame_scheduler(svpwm_pkg::op_t op,
                                                                logic [47:0] data);
        svpwm_pkg::result_t r;
        logic [11:0] w [4];
        logic [11:0] first_w;
        logic [11:0] nearest_w;
        int unsigned e;
        int unsigned delay;
        bit          all_ok;
        bit          found;
        r = '0;
        r.status = svpwm_pkg::ST_OK;
        delay = 1;
        case (op)
            svpwm_pkg::OP_WRITE: begin
                all_ok = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    w[i] = data[12*i +: 12];
                    if (w[i] < svpwm_pkg::PULSE_MIN || w[i] > svpwm_pkg::PULSE_MAX) begin
                        all_ok = 1'b0;
                    end
                end
                // A refused write leaves the whole shadow untouched.
                if (all_ok) begin
                    for (int i = 0; i < 4; i++) shadow_w[i] = w[i];
                end else begin
                    r.status = svpwm_pkg::ST_INVALID;
                end
            end
            svpwm_pkg::OP_START: begin
                if (running) begin
                    r.status = svpwm_pkg::ST_BUSY;
                end else begin
                    r.pins_low_mask = ALL_CHANNELS;
                    running = 1'b1;
                    in_gap = 1'b1;
                    r.reload_timer = 1'b1;
                    delay = 1;
                end
            end
            svpwm_pkg::OP_STOP: begin
                running = 1'b0;
                falling_due = '0;
                r.pins_low_mask = ALL_CHANNELS;
            end
            default: begin
                if (!running) begin
                    r.pins_low_mask = ALL_CHANNELS;
                end else if (in_gap) begin
                    // The gap is over: latch the shadow and raise every pin.
                    first_w = svpwm_pkg::PULSE_MAX;
                    for (int i = 0; i < 4; i++) begin
                        active_w[i] = shadow_w[i];
                        if (active_w[i] < first_w) first_w = active_w[i];
                    end
                    elapsed_us = '0;
                    falling_due = ALL_CHANNELS;
                    in_gap = 1'b0;
                    frames_begun = frames_begun + 32'd1;
                    r.pins_high_mask = ALL_CHANNELS;
                    r.reload_timer = 1'b1;
                    delay = 32'(first_w);
                end else begin
                    e = 32'(elapsed_us) + 32'(reload_us);
                    if (e > 32'(svpwm_pkg::ELAPSED_MAX)) e = 32'(svpwm_pkg::ELAPSED_MAX);
                    elapsed_us = e[11:0];
                    nearest_w = svpwm_pkg::PULSE_MAX;
                    found = 1'b0;
                    for (int i = 0; i < 4; i++) begin
                        if (falling_due[i]) begin
                            if (32'(active_w[i]) <= e) begin
                                r.pins_low_mask[i] = 1'b1;
                                falling_due[i] = 1'b0;
                            end else if (!found || active_w[i] < nearest_w) begin
                                nearest_w = active_w[i];
                                found = 1'b1;
                            end
                        end
                    end
                    r.reload_timer = 1'b1;
                    if (falling_due == '0) begin
                        // Last pin has fallen: wait out the rest of the frame.
                        in_gap = 1'b1;
                        delay = (e < 32'(svpwm_pkg::FRAME_US))
                                ? 32'(svpwm_pkg::FRAME_US) - e : 1;
                    end else begin
                        delay = (32'(nearest_w) > e) ? 32'(nearest_w) - e : 1;
                    end
                end
            end
        endcase
        if (r.reload_timer) begin
            if (delay < 1) delay = 1;
            if (delay > 32'h7FFF) delay = 32'h7FFF;
            r.next_interval = delay[14:0];
            reload_us = r.next_interval;
        end
        r.frame_count = frames_begun;
        r.is_running = running;
        return r;
    endfunction

    // Offers one event word, waits until it is taken and records the answer it must get.
    task automatic issue_event(svpwm_pkg::op_t op, logic [47:0] data);
        int unsigned gap;
        gap = idling_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= op;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        scheduler_replies.push_back(step_frame_scheduler(op, data));
        events_by_op[op]++;
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compares the word just taken from the result channel with the oldest expectation.
    task automatic check_reply();
        svpwm_pkg::result_t want;
        if (scheduler_replies.size() == 0) begin
            $error("result word arrived with no event awaiting an answer");
            error_count++;
        end else begin
            want = scheduler_replies.pop_front();
            compare_field("status", want.status, m_axis_tuser);
            compare_field("pins_high_mask", want.pins_high_mask, m_axis_tdata[3:0]);
            compare_field("pins_low_mask", want.pins_low_mask, m_axis_tdata[7:4]);
            compare_field("reload_timer", want.reload_timer, m_axis_tdata[8]);
            compare_field("next_interval", want.next_interval, m_axis_tdata[23:9]);
            compare_field("frame_count", want.frame_count, m_axis_tdata[55:24]);
            compare_field("is_running", want.is_running, m_axis_tdata[56]);
            compare_field("padding", 0, m_axis_tdata[63:57]);
            if (want.status == svpwm_pkg::ST_INVALID) refused_writes++;
            if (want.status == svpwm_pkg::ST_BUSY) busy_replies++;
            words_checked++;
        end
    endtask

    // Result side: stalls at random, then takes one word and checks it.
    initial begin
        int unsigned stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = idling_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(posedge aclk);
            while (!m_axis_tvalid) @(posedge aclk);
            check_reply();
        end
    end

    // Events before any start: every pin is held low and nothing is scheduled.
    task automatic test_stopped_generator();
        issue_event(svpwm_pkg::OP_TIMER, pack_widths(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
        issue_event(svpwm_pkg::OP_STOP, '0);
        issue_event(svpwm_pkg::OP_STOP, '0);
    endtask

    // Shadow writes just inside, just outside and far outside the permitted pulse range.
    task automatic test_shadow_limits();
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd499, 12'd1500, 12'd1500, 12'd1500));
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd1500, 12'd1500, 12'd1500, 12'd2501));
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd0, 12'hFFF, 12'd0, 12'hFFF));
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd500, 12'd2500, 12'd500, 12'd2500));
    endtask

    // A start from idle, then a second start that must be refused as busy.
    task automatic test_start_busy();
        issue_event(svpwm_pkg::OP_START, '0);
        issue_event(svpwm_pkg::OP_START, pack_widths(12'd500, 12'd500, 12'd500, 12'd500));
    endtask

    // Whole frames, with two channels falling together and a write while running.
    task automatic test_frame_sequence();
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd600, 12'd1200, 12'd1200, 12'd2500));
        repeat (5) issue_event(svpwm_pkg::OP_TIMER, '0);
        issue_event(svpwm_pkg::OP_WRITE, pack_widths(12'd2500, 12'd2500, 12'd2500, 12'd2500));
        repeat (4) issue_event(svpwm_pkg::OP_TIMER, '0);
    endtask

    // Stop in the middle of a frame, expire while stopped, then restart.
    task automatic test_stop_restart();
        issue_event(svpwm_pkg::OP_TIMER, '0);
        issue_event(svpwm_pkg::OP_STOP, '0);
        issue_event(svpwm_pkg::OP_TIMER, '0);
        issue_event(svpwm_pkg::OP_START, '0);
        issue_event(svpwm_pkg::OP_TIMER, '0);
        issue_event(svpwm_pkg::OP_TIMER, '0);
    endtask

    // Mostly well-formed traffic: frequent expiries, valid shadow writes and the odd
    // start or stop, with some fully random words mixed in.
    task automatic test_random_traffic(int unsigned count);
        logic [47:0] data;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 100 == 0) idling_on = ($urandom_range(0, 3) != 0);
            data[31:0]  = $urandom();
            data[47:32] = 16'($urandom_range(0, 16'hFFFF));
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                issue_event(svpwm_pkg::OP_TIMER, data);
            end else if (pick < 78) begin
                for (int ch = 0; ch < 4; ch++) begin
                    case ($urandom_range(0, 5))
                        0: data[12*ch +: 12] = svpwm_pkg::PULSE_MIN;
                        1: data[12*ch +: 12] = svpwm_pkg::PULSE_MAX;
                        2: data[12*ch +: 12] = (ch > 0) ? data[12*(ch-1) +: 12]
                                                        : svpwm_pkg::PULSE_RESET;
                        default: data[12*ch +: 12] =
                            12'($urandom_range(svpwm_pkg::PULSE_MIN, svpwm_pkg::PULSE_MAX));
                    endcase
                end
                issue_event(svpwm_pkg::OP_WRITE, data);
            end else if (pick < 84) begin
                issue_event(svpwm_pkg::OP_WRITE, data);
            end else if (pick < 91) begin
                issue_event(svpwm_pkg::OP_START, data);
            end else if (pick < 96) begin
                issue_event(svpwm_pkg::OP_STOP, data);
            end else begin
                issue_event(svpwm_pkg::op_t'($urandom_range(0, 3)), data);
            end
        end
        idling_on = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < 4; i++) begin
            shadow_w[i] = svpwm_pkg::PULSE_RESET;
            active_w[i] = svpwm_pkg::PULSE_RESET;
        end
        elapsed_us   = '0;
        reload_us    = svpwm_pkg::MIN_RELOAD;
        falling_due  = '0;
        running      = 1'b0;
        in_gap       = 1'b1;
        frames_begun = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_stopped_generator();
        test_shadow_limits();
        test_start_busy();
        test_frame_sequence();
        test_stop_restart();
        test_random_traffic(1600);
        s_axis_tvalid <= 1'b0;

        // Let the output buffer drain, then keep watching for stray words.
        while (scheduler_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Checked %0d result words: %0d expiries, %0d starts, %0d stops, %0d writes.",
                 words_checked, events_by_op[svpwm_pkg::OP_TIMER],
                 events_by_op[svpwm_pkg::OP_START], events_by_op[svpwm_pkg::OP_STOP],
                 events_by_op[svpwm_pkg::OP_WRITE]);
        $display("Frames begun %0d, shadow writes refused %0d, busy replies %0d.",
                 frames_begun, refused_writes, busy_replies);
        if (error_count == 0 && scheduler_replies.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
